// ===== src/hairline_dda_line_stepper_defines.svh =====
// assertion macros used by the line stepper back end
`ifndef HAIRLINE_DDA_LINE_STEPPER_DEFINES_SVH
`define HAIRLINE_DDA_LINE_STEPPER_DEFINES_SVH
`ifndef SYNTHESIS
`define HDLS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hdls assertion failed");
`define HDLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdls assertion failed");
`else
`define HDLS_ASSERT(lbl, prop)
`define HDLS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/hdls_pkg.sv =====
// types and constants of the hairline line stepper
package hdls_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [5:0] HALF_PIXEL_DOT6 = 6'd32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [4:0] DIV_STEPS = 5'd17;

    typedef struct packed {
        logic               command;
        logic               vertical;
        logic               neg;
        logic               degen;
        logic [21:0]        min_mag;
        logic [21:0]        maj_mag;
        logic signed [21:0] min0;
        logic [5:0]         frac;
        logic signed [16:0] pos;
        logic signed [16:0] stop;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [21:0] num;
        logic [21:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic [16:0] quot;
    } div_rsp_t;

endpackage

// ===== src/hdls_front.sv =====
// front end: input register and segment classification
module hdls_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic signed [21:0]  start_x,
    input  logic signed [21:0]  start_y,
    input  logic signed [21:0]  end_x,
    input  logic signed [21:0]  end_y,
    output logic                push,
    output hdls_pkg::entry_t    push_data,
    input  logic                q_full
);

    logic               hold_valid_reg;
    logic               hold_valid_next;
    logic               cmd_reg;
    logic signed [21:0] sx_reg;
    logic signed [21:0] sy_reg;
    logic signed [21:0] ex_reg;
    logic signed [21:0] ey_reg;
    logic               take;

    logic [22:0] dx;
    logic [22:0] dy;
    logic [22:0] ndx;
    logic [22:0] ndy;
    logic [21:0] adx;
    logic [21:0] ady;
    logic        vertical;
    logic        swap;
    logic [21:0] maj_s;
    logic [21:0] maj_e;
    logic [21:0] min_s;
    logic [21:0] min_e;
    logic [21:0] maj0;
    logic [21:0] maj1;
    logic [22:0] r0;
    logic [22:0] r1;

    assign in_stall = hold_valid_reg && q_full;
    assign take     = in_valid && !in_stall;
    assign push     = hold_valid_reg && !q_full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= command;
            sx_reg  <= start_x;
            sy_reg  <= start_y;
            ex_reg  <= end_x;
            ey_reg  <= end_y;
        end
    end

    // major axis, ordering along it and rounding of the major ends
    always_comb
    begin
        dx  = {ex_reg[21], ex_reg} - {sx_reg[21], sx_reg};
        dy  = {ey_reg[21], ey_reg} - {sy_reg[21], sy_reg};
        ndx = -dx;
        ndy = -dy;
        adx = dx[22] ? ndx[21:0] : dx[21:0];
        ady = dy[22] ? ndy[21:0] : dy[21:0];
        vertical = !(adx > ady);
        swap  = vertical ? dy[22] : dx[22];
        maj_s = vertical ? sy_reg : sx_reg;
        maj_e = vertical ? ey_reg : ex_reg;
        min_s = vertical ? sx_reg : sy_reg;
        min_e = vertical ? ex_reg : ey_reg;
        maj0  = swap ? maj_e : maj_s;
        maj1  = swap ? maj_s : maj_e;
        r0    = {maj0[21], maj0} + 23'd32;
        r1    = {maj1[21], maj1} + 23'd32;

        push_data.command  = cmd_reg;
        push_data.vertical = vertical;
        push_data.neg      = dx[22] ^ dy[22];
        push_data.min_mag  = vertical ? adx : ady;
        push_data.maj_mag  = vertical ? ady : adx;
        push_data.min0     = swap ? min_e : min_s;
        push_data.frac     = hdls_pkg::HALF_PIXEL_DOT6 - maj0[5:0];
        push_data.pos      = r0[22:6];
        push_data.stop     = r1[22:6];
        push_data.degen    = (r0[22:6] == r1[22:6]);
    end

endmodule

// ===== src/hdls_queue.sv =====
// two-entry queue between the front end and the stepping back end
module hdls_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hdls_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output hdls_pkg::entry_t head,
    output logic             empty
);

    hdls_pkg::entry_t                 store_reg [hdls_pkg::QUEUE_DEPTH];
    logic [hdls_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [hdls_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [hdls_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [hdls_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [hdls_pkg::QCNT_W-1:0]      count_reg;
    logic [hdls_pkg::QCNT_W-1:0]      count_next;

    assign full  = (count_reg == hdls_pkg::QCNT_W'(hdls_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/hdls_div.sv =====
// shift-subtract divider for the slope magnitude, one quotient bit a cycle
module hdls_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  hdls_pkg::div_req_t req,
    output hdls_pkg::div_rsp_t rsp
);

    logic [4:0]  count_reg;
    logic [4:0]  count_next;
    logic [22:0] rem_reg;
    logic [21:0] den_reg;
    logic [16:0] quot_reg;
    logic [23:0] diff;
    logic        ge;
    logic [22:0] rem_sub;

    // numerator magnitude never exceeds the divisor, so 17 quotient bits suffice
    always_comb
    begin
        diff    = {1'b0, rem_reg} - {2'b00, den_reg};
        ge      = !diff[23];
        rem_sub = ge ? diff[22:0] : rem_reg;
        count_next = count_reg;
        if (req.start)
        begin
            count_next = hdls_pkg::DIV_STEPS;
        end
        else if (count_reg != 5'd0)
        begin
            count_next = count_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {1'b0, req.num};
            den_reg <= req.den;
        end
        else if (count_reg != 5'd0)
        begin
            rem_reg  <= {rem_sub[21:0], 1'b0};
            quot_reg <= {quot_reg[15:0], ge};
        end
    end

    assign rsp.busy = (count_reg != 5'd0);
    assign rsp.quot = quot_reg;

endmodule

// ===== src/hdls_back.sv =====
// back end: segment set-up, pixel stepping and output register
`include "hairline_dda_line_stepper_defines.svh"
module hdls_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  hdls_pkg::entry_t   head,
    input  logic               q_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic               last_pixel
);

    typedef enum logic [2:0]
    {
        ST_FETCH  = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_SEED   = 3'b100
    } back_state_t;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic               active_reg;
    logic               active_next;
    logic signed [16:0] pos_reg;
    logic signed [16:0] pos_next;
    logic signed [16:0] stop_reg;
    logic signed [16:0] stop_next;
    logic signed [32:0] acc_reg;
    logic signed [32:0] acc_next;
    logic signed [17:0] slope_reg;
    logic signed [17:0] slope_next;
    logic               vert_reg;
    logic               vert_next;
    logic               neg_reg;
    logic               neg_next;
    logic signed [21:0] min0_reg;
    logic signed [21:0] min0_next;
    logic [5:0]         frac_reg;
    logic [5:0]         frac_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        px_reg;
    logic [15:0]        px_next;
    logic [15:0]        py_reg;
    logic [15:0]        py_next;
    logic               last_reg;
    logic               last_next;

    hdls_pkg::div_req_t div_req;
    hdls_pkg::div_rsp_t div_rsp;

    logic               out_free;
    logic               emit;
    logic               last_now;
    logic [16:0]        pos_inc;
    logic [17:0]        q_ext;
    logic [17:0]        q_neg;
    logic signed [24:0] prod;
    logic [18:0]        tshift;
    logic [32:0]        seed;

    hdls_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign pos_inc  = pos_reg + 17'd1;
    assign last_now = (pos_inc == stop_reg);
    assign emit     = (state_reg == ST_FETCH) && !q_empty
                      && (head.command == hdls_pkg::CMD_STEP) && active_reg && out_free;

    always_comb
    begin
        q_ext  = {1'b0, div_rsp.quot};
        q_neg  = -q_ext;
        prod   = 25'(slope_reg) * 25'($signed({1'b0, frac_reg}));
        tshift = prod[24:6];
        seed   = {min0_reg[21], min0_reg, 10'd0} + {{14{tshift[18]}}, tshift};
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        pos_next    = pos_reg;
        stop_next   = stop_reg;
        acc_next    = acc_reg;
        slope_next  = slope_reg;
        vert_next   = vert_reg;
        neg_next    = neg_reg;
        min0_next   = min0_reg;
        frac_next   = frac_reg;
        pop         = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = head.min_mag;
        div_req.den   = head.maj_mag;

        case (state_reg)
            ST_FETCH:
            begin
                if (!q_empty)
                begin
                    if (head.command == hdls_pkg::CMD_LOAD)
                    begin
                        pop         = 1'b1;
                        active_next = 1'b0;
                        pos_next    = head.pos;
                        stop_next   = head.stop;
                        vert_next   = head.vertical;
                        neg_next    = head.neg;
                        min0_next   = head.min0;
                        frac_next   = head.frac;
                        if (!head.degen)
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIVIDE;
                        end
                    end
                    else if (!active_reg)
                    begin
                        pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        pop      = 1'b1;
                        pos_next = pos_inc;
                        acc_next = acc_reg + {{15{slope_reg[17]}}, slope_reg};
                        if (last_now)
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (!div_rsp.busy)
                begin
                    slope_next = neg_reg ? q_neg : q_ext;
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                acc_next    = seed;
                active_next = 1'b1;
                state_next  = ST_FETCH;
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            px_next        = vert_reg ? acc_reg[31:16] : pos_reg[15:0];
            py_next        = vert_reg ? pos_reg[15:0] : acc_reg[31:16];
            last_next      = last_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FETCH;
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            acc_reg       <= '0;
            slope_reg     <= '0;
            vert_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            stop_reg      <= stop_next;
            acc_reg       <= acc_next;
            slope_reg     <= slope_next;
            vert_reg      <= vert_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        min0_reg <= min0_next;
        frac_reg <= frac_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last_pixel = last_reg;

    `HDLS_ASSERT(a_div_only_in_divide, div_rsp.busy |-> (state_reg == ST_DIVIDE))
    `HDLS_ASSERT_NEXT(a_last_ends_segment, emit && last_now, !active_reg)
    `HDLS_ASSERT(a_emit_inside_segment, emit |-> (pos_reg < stop_reg))

endmodule

// ===== src/hairline_dda_line_stepper.sv =====
// top level of the hairline line stepper
// A run of step commands gives one pixel per cycle while the output is not stalled.
// A load that draws something holds the back end while it is taken, while the
// shift-subtract slope divider works (one quotient bit a cycle), while the quotient
// is picked up and while the minor accumulator is seeded; a load whose rounded major
// ends coincide is only taken. Commands pass an input register and a two-entry queue,
// so the input takes up to three further transfers while a load is divided. At the
// earliest, a step whose segment is ready passes the input register, the queue and
// the output register before its pixel shows on the output.
module hairline_dda_line_stepper
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [21:0] start_x,
    input  logic signed [21:0] start_y,
    input  logic signed [21:0] end_x,
    input  logic signed [21:0] end_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic               last_pixel
);

    logic             push;
    hdls_pkg::entry_t push_data;
    logic             q_full;
    logic             q_empty;
    logic             pop;
    hdls_pkg::entry_t head;

    hdls_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    hdls_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    hdls_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

// ===== bench/hairline_dda_line_stepper_test.sv =====
// testbench of the hairline line stepper: directed rows, random segments, pixel prediction
module hairline_dda_line_stepper_test;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } pixel_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_PIXEL} row_kind_t;

    typedef struct packed {
        logic               cmd;
        logic signed [21:0] sx;
        logic signed [21:0] sy;
        logic signed [21:0] ex;
        logic signed [21:0] ey;
        row_kind_t          kind;
        pixel_t             pix;
    } row_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               command   = hdls_pkg::CMD_STEP;
    logic signed [21:0] start_x   = '0;
    logic signed [21:0] start_y   = '0;
    logic signed [21:0] end_x     = '0;
    logic signed [21:0] end_y     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               last_pixel;

    // predicted stepper state
    logic signed [16:0] line_pos      = '0;
    logic signed [16:0] line_stop     = '0;
    logic signed [32:0] line_acc      = '0;
    logic signed [17:0] line_slope    = '0;
    logic               line_vertical = 1'b0;
    logic               line_active   = 1'b0;

    pixel_t      pending_pixels [$];
    bit          steady        = 1'b0;
    int          mismatches    = 0;
    int          pixels_taken  = 0;
    int          counted_items = 0;
    int unsigned cycles        = 0;

    hairline_dda_line_stepper dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    function automatic row_t row_of(logic cmd, int sx, int sy, int ex, int ey, row_kind_t kind,
                                    int px = 0, int py = 0, logic pl = 1'b0);
        row_t r;
        r.cmd      = cmd;
        r.sx       = 22'(sx);
        r.sy       = 22'(sy);
        r.ex       = 22'(ex);
        r.ey       = 22'(ey);
        r.kind     = kind;
        r.pix.x    = 16'(px);
        r.pix.y    = 16'(py);
        r.pix.last = pl;
        return r;
    endfunction

    function automatic logic signed [21:0] clamp22(longint v);
        if (v > 2097151)
        begin
            return 22'sh1FFFFF;
        end
        if (v < -2097152)
        begin
            return 22'sh200000;
        end
        return 22'(v);
    endfunction

    task automatic load_line(input logic signed [21:0] sx, sy, ex, ey);
        longint x0, y0, x1, y1, dx, dy, adx, ady;
        longint maj0, maj1, min0, dmaj, dmin, frac;
        x0  = sx;
        y0  = sy;
        x1  = ex;
        y1  = ey;
        dx  = x1 - x0;
        dy  = y1 - y0;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx > ady)
        begin
            line_vertical = 1'b0;
            dmaj = dx;
            dmin = dy;
            if (x0 > x1)
            begin
                maj0 = x1;
                maj1 = x0;
                min0 = y1;
            end
            else
            begin
                maj0 = x0;
                maj1 = x1;
                min0 = y0;
            end
        end
        else
        begin
            line_vertical = 1'b1;
            dmaj = dy;
            dmin = dx;
            if (y0 > y1)
            begin
                maj0 = y1;
                maj1 = y0;
                min0 = x1;
            end
            else
            begin
                maj0 = y0;
                maj1 = y1;
                min0 = x0;
            end
        end
        line_pos  = 17'((maj0 + 32) >>> 6);
        line_stop = 17'((maj1 + 32) >>> 6);
        if (line_pos == line_stop)
        begin
            line_active = 1'b0;
            return;
        end
        // minor delta never exceeds major delta, so the slope fits 18 bits
        line_slope  = 18'((dmin * 65536) / dmaj);
        frac        = (32 - maj0) & 63;
        line_acc    = 33'(min0 * 1024 + ((longint'(line_slope) * frac) >>> 6));
        line_active = 1'b1;
    endtask

    task automatic step_line(output bit got, output pixel_t px);
        logic [15:0] major_px;
        logic [15:0] minor_px;
        got = line_active;
        px  = '0;
        if (!line_active)
        begin
            return;
        end
        major_px  = line_pos[15:0];
        minor_px  = line_acc[31:16];
        px.x      = line_vertical ? minor_px : major_px;
        px.y      = line_vertical ? major_px : minor_px;
        px.last   = (line_pos + 17'sd1 == line_stop);
        line_pos  = line_pos + 17'sd1;
        line_acc  = line_acc + 33'(line_slope);
        if (px.last)
        begin
            line_active = 1'b0;
        end
    endtask

    task automatic issue(input logic cmd, input logic signed [21:0] sx, sy, ex, ey,
                         input row_kind_t kind, input pixel_t typed);
        int     gap;
        bit     got;
        pixel_t px;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        do @(posedge clk); while (in_stall);
        counted_items++;
        if (cmd == hdls_pkg::CMD_LOAD)
        begin
            load_line(sx, sy, ex, ey);
        end
        else
        begin
            step_line(got, px);
            if (kind == ROW_PIXEL)
            begin
                pending_pixels.push_back(typed);
            end
            else if (kind == ROW_PREDICT && got)
            begin
                pending_pixels.push_back(px);
            end
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        pixels_taken++;
        if (pending_pixels.size() == 0)
        begin
            $error("unexpected pixel x=%0d y=%0d last=%0d", pixel_x, pixel_y, last_pixel);
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        if (pixel_x !== want.x)
        begin
            $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
            mismatches++;
        end
        if (pixel_y !== want.y)
        begin
            $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
            mismatches++;
        end
        if (last_pixel !== want.last)
        begin
            $error("last_pixel: expected %0d, got %0d", want.last, last_pixel);
            mismatches++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // receiving side, with a long hold-off now and then so the input backs up
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            if (pixels_taken == 60 || pixels_taken == 300)
            begin
                hold = HOLD_CYCLES;
            end
            else
            begin
                hold = steady ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            check_pixel();
        end
    end

    initial
    begin
        row_t               rows [25];
        logic signed [21:0] sx, sy, ex, ey;
        int                 major_len, minor_len, dx, dy;
        int                 pick, runs, npix, base;
        rows = '{
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_NONE),          // step after reset
            row_of(hdls_pkg::CMD_LOAD, 0, 0, 0, 0, ROW_NONE),          // equal endpoints
            row_of(hdls_pkg::CMD_STEP, -1, -1, -1, -1, ROW_NONE),      // step while idle
            row_of(hdls_pkg::CMD_LOAD, 0, 0, 192, 0, ROW_NONE),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PIXEL, 0, 0, 1'b0),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PIXEL, 1, 0, 1'b0),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PIXEL, 2, 0, 1'b1),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_NONE),          // past the last pixel
            row_of(hdls_pkg::CMD_LOAD, 0, 0, 0, 128, ROW_NONE),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PIXEL, 0, 0, 1'b0),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PIXEL, 0, 1, 1'b1),
            row_of(hdls_pkg::CMD_LOAD, 0, 192, 192, 0, ROW_NONE),      // reversed diagonal
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PREDICT),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PREDICT),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PREDICT),
            row_of(hdls_pkg::CMD_LOAD, -2097152, 0, 2097151, 0, ROW_NONE), // full width
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PIXEL, -32768, 0, 1'b0),
            // replaces live segment
            row_of(hdls_pkg::CMD_LOAD, 0, -2097152, 0, 2097151, ROW_NONE),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PIXEL, 0, -32768, 1'b0),
            row_of(hdls_pkg::CMD_STEP, -1, -1, -1, -1, ROW_PREDICT),
            // rounds to top
            row_of(hdls_pkg::CMD_LOAD, 2097151, 2097151, 2097120, 2097130, ROW_NONE),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_NONE),
            row_of(hdls_pkg::CMD_LOAD, 33, -100, 700, 333, ROW_NONE),  // far past centre
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PREDICT),
            row_of(hdls_pkg::CMD_STEP, 0, 0, 0, 0, ROW_PREDICT)
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            issue(rows[i].cmd, rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey,
                  rows[i].kind, rows[i].pix);
        end

        base = counted_items;
        while (counted_items - base < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 7) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 85)
            begin
                major_len = (pick < 5) ? $urandom_range(0, 4096) : $urandom_range(0, 768);
                minor_len = $urandom_range(0, major_len);
                if ($urandom_range(0, 1))
                begin
                    major_len = -major_len;
                end
                if ($urandom_range(0, 1))
                begin
                    minor_len = -minor_len;
                end
                if ($urandom_range(0, 1))
                begin
                    dx = major_len;
                    dy = minor_len;
                end
                else
                begin
                    dx = minor_len;
                    dy = major_len;
                end
                sx = 22'($urandom);
                sy = 22'($urandom);
                ex = clamp22(longint'(sx) + dx);
                ey = clamp22(longint'(sy) + dy);
            end
            else
            begin
                sx = 22'($urandom);
                sy = 22'($urandom);
                ex = 22'($urandom);
                ey = 22'($urandom);
            end
            if (pick < 95)
            begin
                issue(hdls_pkg::CMD_LOAD, sx, sy, ex, ey, ROW_PREDICT, '0);
                npix = line_active ? int'(line_stop) - int'(line_pos) : 0;
                if (pick < 75)
                begin
                    runs = (npix > 70 ? 70 : npix) + $urandom_range(0, 1);
                end
                else if (pick < 85)
                begin
                    // cut short, the next load takes over
                    runs = npix > 0 ? $urandom_range(0, npix - 1) : 0;
                end
                else
                begin
                    runs = $urandom_range(1, 4);
                end
                repeat (runs)
                begin
                    issue(hdls_pkg::CMD_STEP, 22'($urandom), 22'($urandom), 22'($urandom),
                          22'($urandom), ROW_PREDICT, '0);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    issue($urandom_range(0, 1) ? hdls_pkg::CMD_STEP : hdls_pkg::CMD_LOAD,
                          22'($urandom), 22'($urandom), 22'($urandom), 22'($urandom),
                          ROW_PREDICT, '0);
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
